### design/isort_pkg.sv
// Package for the insertion sorter: default sizes and the control word
// that the top level broadcasts to every cell of the sorting chain.
// No dependencies.
package isort_pkg;

    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Per-cycle command to all cells: insert the broadcast value, or shift
    // the whole chain down by one place towards the output.
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

endpackage

### design/isort_cell.sv
// One cell of the systolic insertion chain: holds a single value and its
// valid bit, and trades data with its two neighbours every cycle.
// Depends on isort_pkg.
module isort_cell #(
    parameter int DATA_WIDTH = isort_pkg::DEF_DATA_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  isort_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0]   i_new_value,
    input  logic                    i_prev_valid,
    input  logic                    i_prev_gt,
    input  logic [DATA_WIDTH-1:0]   i_prev_value,
    input  logic                    i_next_valid,
    input  logic [DATA_WIDTH-1:0]   i_next_value,
    output logic                    o_valid,
    output logic                    o_gt,
    output logic [DATA_WIDTH-1:0]   o_value
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_value;
    logic                  n_valid;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  gt;

    // Strictly greater keeps the sort stable: equal values stay in front.
    assign gt = r_valid && ($signed(r_value) > $signed(i_new_value));

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.drain) begin
            n_valid = i_next_valid;
            n_value = i_next_value;
        end else if (i_ctl.insert) begin
            if (i_prev_gt) begin
                n_valid = 1'b1;
                n_value = i_prev_value;
            end else if (i_prev_valid && (!r_valid || gt)) begin
                n_valid = 1'b1;
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_gt    = gt;
    assign o_value = r_value;

endmodule

### design/insertion_sorter_core.sv
// Top level of the streaming insertion sorter: a chain of isort_cell
// instances plus the drain control and the registered result port.
// Depends on isort_pkg and isort_cell.
//
// Usage:
//   An input transaction is taken at a rising edge where start is high and
//   busy is low; it carries i_value (signed) and i_last. Each value is
//   placed directly in the chain of MAX_ITEMS cells, every cell
//   comparing against the broadcast value and shifting up locally, so
//   ordinary items are accepted one per cycle. Once the store is full,
//   further values are dropped and the overflow flag is raised.
//   After the transaction marked last, busy goes high from the next cycle
//   and the chain shifts down one place a cycle, handing out the held
//   values in ascending order: n results for n held values, one per cycle,
//   the first reaching the port via busy and the output register. Each result
//   shows on o_sorted_value for one cycle with o_valid high; o_run_end marks
//   the final one and o_overflow is set on every result of a run that lost
//   values. busy falls in the cycle that shows the final result. The
//   receiver cannot stall the result stream.
//   A synchronous reset empties the chain and clears all flags.
module insertion_sorter_core #(
    parameter int MAX_ITEMS  = isort_pkg::DEF_MAX_ITEMS,
    parameter int DATA_WIDTH = isort_pkg::DEF_DATA_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic                   i_last,
    output logic                   o_valid,
    output logic [DATA_WIDTH-1:0]  o_sorted_value,
    output logic                   o_run_end,
    output logic                   o_overflow
);

    logic                  cell_valid [MAX_ITEMS];
    logic                  cell_gt    [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] cell_value [MAX_ITEMS];

    isort_pkg::t_cell_ctl  ctl;
    logic                  accept;
    logic                  full;
    logic                  emit;

    logic                  r_draining;
    logic                  r_dropped;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic                  r_out_end;
    logic                  r_out_ovf;

    assign accept     = start && !r_draining;
    assign full       = cell_valid[MAX_ITEMS-1];
    assign emit       = r_draining && cell_valid[0];
    assign ctl.insert = accept && !full;
    assign ctl.drain  = emit;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic                  prev_valid;
        logic                  prev_gt;
        logic [DATA_WIDTH-1:0] prev_value;
        logic                  next_valid;
        logic [DATA_WIDTH-1:0] next_value;

        if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
            assign prev_value = '0;
        end else begin : g_body
            assign prev_valid = cell_valid[g-1];
            assign prev_gt    = cell_gt[g-1];
            assign prev_value = cell_value[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_value = '0;
        end else begin : g_inner
            assign next_valid = cell_valid[g+1];
            assign next_value = cell_value[g+1];
        end

        isort_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_new_value  (i_value),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .i_prev_value (prev_value),
            .i_next_valid (next_valid),
            .i_next_value (next_value),
            .o_valid      (cell_valid[g]),
            .o_gt         (cell_gt[g]),
            .o_value      (cell_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining  <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_end   <= 1'b0;
            r_out_ovf   <= 1'b0;
        end else begin
            r_out_valid <= emit;
            r_out_end   <= emit && !(MAX_ITEMS > 1 ? cell_valid[1 % MAX_ITEMS] : 1'b0);
            r_out_ovf   <= emit && r_dropped;
            if (accept) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end
                if (i_last) begin
                    r_draining <= 1'b1;
                end
            end else if (r_draining) begin
                // The final value leaves when its upper neighbour is empty.
                if (!cell_valid[0] || !cell_valid[1 % MAX_ITEMS]) begin
                    r_draining <= 1'b0;
                    r_dropped  <= 1'b0;
                end
            end
        end
        r_out_value <= cell_value[0];
    end

    assign busy           = r_draining;
    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_run_end      = r_out_end;
    assign o_overflow     = r_out_ovf;

endmodule

### design/isort_chk.sv
// Port-level checker for insertion_sorter_core and the bind that attaches it.
// Depends on insertion_sorter_core's port list only.
module isort_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_valid,
    input logic o_run_end,
    input logic o_overflow
);

    // Results only come out of a drain, which keeps busy high.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding drain");

    a_end_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_end |-> o_valid)
        else $error("run end flagged outside a result");

    // A run is emitted without gaps until its final result.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_end) |=> o_valid)
        else $error("gap inside a sorted run");

    a_run_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_end) |=> !o_valid)
        else $error("result after the end of a run");

    // The overflow flag belongs to the whole run and cannot change inside it.
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_end) |=> (o_overflow == $past(o_overflow)))
        else $error("overflow flag changed within a run");

endmodule

bind insertion_sorter_core isort_chk u_isort_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_run_end  (o_run_end),
    .o_overflow (o_overflow)
);
